### hdl/bra_pkg.sv
`timescale 1ns / 1ps
// constants, types, tables and interpolation helper for the barometric altitude unit
// no dependencies

package bra_pkg;

    localparam int FRAC_BITS      = 24;
    localparam int LOG_TABLE_BITS = 8;
    localparam int TBL_N          = 1 << LOG_TABLE_BITS;
    localparam int TBL_Q          = 30;
    localparam int IDX_SHIFT      = FRAC_BITS - LOG_TABLE_BITS;
    localparam int Q_SHL          = (FRAC_BITS >= TBL_Q) ? FRAC_BITS - TBL_Q : 0;
    localparam int Q_SHR          = (FRAC_BITS >= TBL_Q) ? 0 : TBL_Q - FRAC_BITS;

    // field widths
    localparam int P_W      = 17;
    localparam int T_W      = 15;
    localparam int ALT_W    = 24;
    localparam int ALPHA_W  = 20;
    localparam int LAPSE_W  = 16;
    localparam int GAIN_W   = 18;
    localparam int GAIN_FRAC = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_PRESSURE     = 3'd0,
        CFG_REF_ALTITUDE     = 3'd1,
        CFG_SEA_PRESSURE     = 3'd2,
        CFG_PRESSURE_EXP     = 3'd3,
        CFG_LAPSE_RATE       = 3'd4,
        CFG_SCALE_GAIN       = 3'd5
    } cfg_index_t;

    localparam logic [P_W-1:0]     RST_REF_PRESSURE = P_W'(101325);
    localparam logic [ALT_W-1:0]   RST_REF_ALTITUDE = '0;
    localparam logic [P_W-1:0]     RST_SEA_PRESSURE = P_W'(101325);
    localparam logic [ALPHA_W-1:0] RST_PRESSURE_EXP = ALPHA_W'(199505);
    localparam logic [LAPSE_W-1:0] RST_LAPSE_RATE   = LAPSE_W'(6500);
    localparam logic [GAIN_W-1:0]  RST_SCALE_GAIN   = GAIN_W'(65536);

    // log2 and exp2 datapath widths
    localparam int E_W      = $clog2(P_W);
    localparam int LOG_W    = FRAC_BITS + E_W;
    localparam int Y_W      = LOG_W + 1;
    localparam int N_W      = Y_W - FRAC_BITS;
    localparam int TAB_W    = FRAC_BITS + 2;
    localparam int EXP_SHL_MAX = 20;
    localparam int POW_W    = TAB_W + EXP_SHL_MAX;

    // temperature over lapse rate
    localparam int TK_W       = 16;
    localparam int T_OFFSET   = 27315;
    localparam int MICRO_W    = 20;
    localparam int MICRO      = 1000000;
    localparam int TKM_W      = TK_W + MICRO_W;
    localparam int Q16_SHIFT  = 16;
    localparam int NUM_W      = TKM_W + Q16_SHIFT;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;

    // output range
    localparam int OUT_LOW  = -1000000;
    localparam int OUT_HIGH = 5000000;

    typedef logic [TBL_N-1:0][TAB_W-1:0] tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = xin;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > x) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] q30_to_f(input logic [63:0] v);
        return (v << Q_SHL) >> Q_SHR;
    endfunction

    // log2(1+i/N) by repeated squaring
    function automatic tab_t build_log_tab();
        tab_t t;
        logic [63:0] v;
        logic [63:0] lg;
        for (int i = 0; i < TBL_N; i++) begin
            v  = 64'(TBL_N + i) << (TBL_Q - LOG_TABLE_BITS);
            lg = '0;
            for (int k = 0; k < TBL_Q; k++) begin
                v = (v * v) >> TBL_Q;
                if (v >= (64'd2 << TBL_Q)) begin
                    v  = v >> 1;
                    lg = lg | (64'd1 << (TBL_Q - 1 - k));
                end
            end
            t[i] = TAB_W'(q30_to_f(lg));
        end
        return t;
    endfunction

    // 2^(i/N) as product of nested square roots of two
    function automatic tab_t build_pow_tab();
        tab_t t;
        logic [63:0] roots [LOG_TABLE_BITS+1];
        logic [63:0] p;
        roots[0] = 64'd2 << TBL_Q;
        for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
            roots[k] = isqrt64(roots[k-1] << TBL_Q);
        end
        for (int i = 0; i < TBL_N; i++) begin
            p = 64'd1 << TBL_Q;
            for (int k = 0; k < LOG_TABLE_BITS; k++) begin
                if (((i >> k) & 1) != 0) p = (p * roots[LOG_TABLE_BITS - k]) >> TBL_Q;
            end
            t[i] = TAB_W'(q30_to_f(p));
        end
        return t;
    endfunction

    localparam tab_t LOG_TAB = build_log_tab();
    localparam tab_t POW_TAB = build_pow_tab();
    localparam logic [TAB_W-1:0] LOG_TAB_LAST = TAB_W'(1) << FRAC_BITS;
    localparam logic [TAB_W-1:0] POW_TAB_LAST = TAB_W'(2) << FRAC_BITS;

    // table lookup with linear interpolation on the low fraction bits
    function automatic logic [TAB_W-1:0] interp(input tab_t tab, input logic [TAB_W-1:0] last,
                                                input logic [FRAC_BITS-1:0] frac);
        logic [LOG_TABLE_BITS-1:0]    idx;
        logic [IDX_SHIFT-1:0]         r;
        logic [TAB_W-1:0]             t0;
        logic [TAB_W-1:0]             t1;
        logic [TAB_W-1:0]             d;
        logic [TAB_W+IDX_SHIFT-1:0]   prod;
        idx  = frac[FRAC_BITS-1:IDX_SHIFT];
        r    = frac[IDX_SHIFT-1:0];
        t0   = tab[idx];
        t1   = (idx == {LOG_TABLE_BITS{1'b1}}) ? last : tab[idx + 1'b1];
        d    = (t1 >= t0) ? t1 - t0 : '0;
        prod = (TAB_W+IDX_SHIFT)'(d) * (TAB_W+IDX_SHIFT)'(r);
        return t0 + TAB_W'(prod >> IDX_SHIFT);
    endfunction

endpackage

### hdl/bra_if.sv
`timescale 1ns / 1ps
// valid/ready channels of the barometric altitude unit: sample, result, config write
// depends on bra_pkg

interface bra_in_if;
    import bra_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [P_W-1:0]         pressure_pa;
    logic signed [T_W-1:0]  temperature_centi_c;
    modport source (output valid, output pressure_pa, output temperature_centi_c, input ready);
    modport sink (input valid, input pressure_pa, input temperature_centi_c, output ready);
endinterface

interface bra_out_if;
    import bra_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ALT_W-1:0] altitude_cm;
    logic                    saturated;
    modport source (output valid, output altitude_cm, output saturated, input ready);
    modport sink (input valid, input altitude_cm, input saturated, output ready);
endinterface

interface bra_cfg_if;
    import bra_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/bra_log2.sv
`timescale 1ns / 1ps
// two-stage fixed point log2 of a pressure: normalize, then table interpolation
// depends on bra_pkg

module bra_log2 (
    input  logic                       clk,
    input  logic [1:0]                 en,
    input  logic [bra_pkg::P_W-1:0]    x,
    output logic [bra_pkg::LOG_W-1:0]  lg
);
    import bra_pkg::*;

    logic [E_W-1:0]          e_next;
    logic [E_W-1:0]          e_reg;
    logic [FRAC_BITS-1:0]    frac_next;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [P_W+FRAC_BITS-1:0] sh;
    logic [LOG_W-1:0]        lg_next;
    logic [LOG_W-1:0]        lg_reg;

    // leading one position and mantissa fraction
    always_comb
    begin
        e_next = '0;
        for (int b = 1; b < P_W; b++) begin
            if (x[b]) e_next = E_W'(b);
        end
        sh        = (P_W+FRAC_BITS)'(x) << (FRAC_BITS - int'(e_next));
        frac_next = sh[FRAC_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e_reg    <= e_next;
            frac_reg <= frac_next;
        end
    end

    assign lg_next = (LOG_W'(e_reg) << FRAC_BITS) + LOG_W'(interp(LOG_TAB, LOG_TAB_LAST, frac_reg));

    always_ff @(posedge clk)
    begin
        if (en[1]) lg_reg <= lg_next;
    end

    assign lg = lg_reg;

endmodule

### hdl/bra_exp2.sv
`timescale 1ns / 1ps
// two-stage fixed point exp2: table interpolation of the fraction, then integer shift
// depends on bra_pkg

module bra_exp2 (
    input  logic                             clk,
    input  logic [1:0]                       en,
    input  logic signed [bra_pkg::Y_W-1:0]   y,
    output logic [bra_pkg::POW_W-1:0]        pow
);
    import bra_pkg::*;

    logic signed [N_W-1:0] n_reg;
    logic [TAB_W-1:0]      m_reg;
    logic [N_W:0]          nmag;
    logic [N_W-1:0]        shl;
    logic [POW_W-1:0]      pow_next;
    logic [POW_W-1:0]      pow_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n_reg <= y[Y_W-1:FRAC_BITS];
            m_reg <= interp(POW_TAB, POW_TAB_LAST, y[FRAC_BITS-1:0]);
        end
    end

    // left shift clamps, right shift falls to zero on its own
    always_comb
    begin
        nmag = (N_W+1)'(0) - {n_reg[N_W-1], n_reg};
        shl  = (n_reg > $signed(N_W'(EXP_SHL_MAX))) ? N_W'(EXP_SHL_MAX) : n_reg;
        if (!n_reg[N_W-1]) pow_next = POW_W'(m_reg) << shl;
        else               pow_next = POW_W'(m_reg) >> nmag;
    end

    always_ff @(posedge clk)
    begin
        if (en[1]) pow_reg <= pow_next;
    end

    assign pow = pow_reg;

endmodule

### hdl/bra_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, DIV_BITS (4) quotient bits per stage
// depends on bra_pkg

module bra_div (
    input  logic                              clk,
    input  logic [bra_pkg::DIV_STAGES-1:0]    en,
    input  logic [bra_pkg::NUM_W-1:0]         num,
    input  logic [bra_pkg::LAPSE_W-1:0]       divisor,
    output logic [bra_pkg::NUM_W-1:0]         quot
);
    import bra_pkg::*;

    logic [LAPSE_W-1:0] rem_reg [DIV_STAGES];
    logic [NUM_W-1:0]   wq_reg  [DIV_STAGES];

    // work word: remaining dividend bits on top, quotient bits shift in below
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [LAPSE_W-1:0] rem_in;
        logic [NUM_W-1:0]   wq_in;
        logic [LAPSE_W-1:0] rem_next;
        logic [NUM_W-1:0]   wq_next;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign wq_in  = num;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign wq_in  = wq_reg[s-1];
        end

        always_comb
        begin : p_step
            logic [LAPSE_W:0] t;
            rem_next = rem_in;
            wq_next  = wq_in;
            t        = '0;
            for (int k = 0; k < DIV_BITS; k++) begin
                t       = {rem_next, wq_next[NUM_W-1]};
                wq_next = {wq_next[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, divisor})
                begin
                    t          = t - {1'b0, divisor};
                    wq_next[0] = 1'b1;
                end
                rem_next = t[LAPSE_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next;
                wq_reg[s]  <= wq_next;
            end
        end
    end

    assign quot = wq_reg[DIV_STAGES-1];

endmodule

### hdl/barometric_relative_altitude_unit.sv
`timescale 1ns / 1ps
// top level of the barometric relative altitude unit: config registers and pipeline
// depends on bra_pkg, bra_if, bra_log2, bra_exp2, bra_div
//
// usage
//  sample channel: pressure in Pa and temperature in 0.01 degC, one item per valid/ready
//  result channel: altitude in cm, saturated flag when clipped to [-10 km, 50 km]
//  cfg channel: register index and data, always ready, write only while idle
//  throughput: one item per clock while result.ready holds, every item gives exactly one result
//  depth: 24 register stages from acceptance to result valid;
//   the depth is set by the 13-stage divider for T/L (4 quotient bits per stage)
//   plus the split wide multiplies for the altitude product and the gain
//  stall: each stage has its own valid bit and moves when the stage after it is
//   free, so bubbles are squeezed out and new items still enter while a result
//   waits; with every stage full, sample.ready drops until result.ready
//  reset: the pipeline empties, registers return to standard atmosphere values

module barometric_relative_altitude_unit (
    input  logic  clk,
    input  logic  rst_n,
    bra_in_if.sink     sample,
    bra_out_if.source  result,
    bra_cfg_if.sink    cfg
);
    import bra_pkg::*;

    // stage numbering
    localparam int ST_IN   = 1;
    localparam int ST_LOGA = 2;
    localparam int ST_LOGB = 3;
    localparam int ST_Y    = 4;
    localparam int ST_EXA  = 5;
    localparam int ST_D    = 7;
    localparam int ST_DIV0 = 2;
    localparam int ST_DIVN = ST_DIV0 + DIV_STAGES - 1;
    localparam int DLY_N   = ST_DIVN - ST_D;
    localparam int ST_PP   = ST_DIVN + 1;
    localparam int ST_SUM  = ST_PP + 1;
    localparam int ST_FULL = ST_PP + 2;
    localparam int ST_DQ   = ST_PP + 3;
    localparam int ST_S    = ST_PP + 4;
    localparam int ST_SM   = ST_PP + 5;
    localparam int ST_GP   = ST_PP + 6;
    localparam int ST_TOT  = ST_PP + 7;
    localparam int ST_AM   = ST_PP + 8;
    localparam int NSTAGE  = ST_PP + 9;

    // datapath widths of the back end
    localparam int Q_LO_W  = NUM_W / 2;
    localparam int Q_HI_W  = NUM_W - Q_LO_W;
    localparam int DM_LO_W = POW_W / 2;
    localparam int DM_HI_W = POW_W - DM_LO_W;
    localparam int PROD_W  = NUM_W + POW_W;
    localparam int DQ_W    = 61;
    localparam int S_W     = DQ_W + 2;
    localparam int SM_W    = S_W - 1;
    localparam int SM_LO_W = SM_W / 2;
    localparam int SM_HI_W = SM_W - SM_LO_W;
    localparam int TOT_W   = SM_W + GAIN_W + 1;
    localparam int AM_W    = 41;
    localparam int V_W     = AM_W + 1;
    localparam int RND_SH  = 32;
    localparam logic [DQ_W-1:0] DQ_CAP = DQ_W'(1) << (DQ_W - 1);
    localparam logic [AM_W-1:0] AM_CAP = AM_W'(1) << (AM_W - 1);

    // ---------------- configuration registers ----------------
    logic [P_W-1:0]     ref_pressure_reg;
    logic [ALT_W-1:0]   ref_altitude_reg;
    logic [P_W-1:0]     sea_level_pressure_reg;
    logic [ALPHA_W-1:0] pressure_exponent_reg;
    logic [LAPSE_W-1:0] lapse_rate_reg;
    logic [GAIN_W-1:0]  scale_gain_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_pressure_reg       <= RST_REF_PRESSURE;
            ref_altitude_reg       <= RST_REF_ALTITUDE;
            sea_level_pressure_reg <= RST_SEA_PRESSURE;
            pressure_exponent_reg  <= RST_PRESSURE_EXP;
            lapse_rate_reg         <= RST_LAPSE_RATE;
            scale_gain_reg         <= RST_SCALE_GAIN;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_REF_PRESSURE: ref_pressure_reg       <= cfg.data[P_W-1:0];
                CFG_REF_ALTITUDE: ref_altitude_reg       <= cfg.data[ALT_W-1:0];
                CFG_SEA_PRESSURE: sea_level_pressure_reg <= cfg.data[P_W-1:0];
                CFG_PRESSURE_EXP: pressure_exponent_reg  <= cfg.data[ALPHA_W-1:0];
                CFG_LAPSE_RATE:   lapse_rate_reg         <= cfg.data[LAPSE_W-1:0];
                CFG_SCALE_GAIN:   scale_gain_reg         <= cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero pressures and a zero lapse rate count as one
    logic [P_W-1:0]     pr_eff;
    logic [P_W-1:0]     p0_eff;
    logic [LAPSE_W-1:0] lap_eff;
    assign pr_eff  = (ref_pressure_reg == '0) ? P_W'(1) : ref_pressure_reg;
    assign p0_eff  = (sea_level_pressure_reg == '0) ? P_W'(1) : sea_level_pressure_reg;
    assign lap_eff = (lapse_rate_reg == '0) ? LAPSE_W'(1) : lapse_rate_reg;

    // ---------------- stage valid bits and enables ----------------
    logic [NSTAGE:1]   v_reg;
    logic [NSTAGE:1]   v_prev;
    logic [NSTAGE+1:1] en;

    assign v_prev = {v_reg[NSTAGE-1:1], sample.valid};
    assign en[NSTAGE+1] = result.ready;

    // a stage loads when empty or when its item moves on
    for (genvar k = 1; k <= NSTAGE; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else
        begin
            for (int k = 1; k <= NSTAGE; k++) begin
                if (en[k]) v_reg[k] <= v_prev[k];
            end
        end
    end

    assign sample.ready = en[ST_IN];

    // ---------------- input stage ----------------
    logic [P_W-1:0]       p_reg;
    logic [TKM_W-1:0]     tkm_reg;
    logic signed [TK_W:0] tck;

    // absolute temperature in centi kelvin, always positive over the 15 bit range
    assign tck = (TK_W+1)'(sample.temperature_centi_c) + (TK_W+1)'(T_OFFSET);

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            p_reg   <= (sample.pressure_pa == '0) ? P_W'(1) : sample.pressure_pa;
            tkm_reg <= TKM_W'(tck[TK_W-1:0]) * TKM_W'(MICRO);
        end
    end

    // ---------------- T/L divider ----------------
    logic [NUM_W-1:0] q16;

    bra_div u_div (
        .clk     (clk),
        .en      (en[ST_DIVN:ST_DIV0]),
        .num     ({tkm_reg, Q16_SHIFT'(0)}),
        .divisor (lap_eff),
        .quot    (q16)
    );

    // ---------------- log2 of sample, reference and sea level ----------------
    logic [LOG_W-1:0] lg_s;
    logic [LOG_W-1:0] lg_r;
    logic [LOG_W-1:0] lg_0;

    bra_log2 u_log_s (.clk(clk), .en(en[ST_LOGB:ST_LOGA]), .x(p_reg),  .lg(lg_s));
    bra_log2 u_log_r (.clk(clk), .en(en[ST_LOGB:ST_LOGA]), .x(pr_eff), .lg(lg_r));
    bra_log2 u_log_0 (.clk(clk), .en(en[ST_LOGB:ST_LOGA]), .x(p0_eff), .lg(lg_0));

    // ---------------- exponent scaling ----------------
    logic signed [Y_W-1:0]         l_s;
    logic signed [Y_W-1:0]         l_r;
    logic signed [Y_W+ALPHA_W:0]   prod_s;
    logic signed [Y_W+ALPHA_W:0]   prod_r;
    logic signed [ALPHA_W:0]       alpha_s;
    logic signed [Y_W-1:0]         y_s_reg;
    logic signed [Y_W-1:0]         y_r_reg;

    assign alpha_s = $signed({1'b0, pressure_exponent_reg});
    assign l_s     = $signed({1'b0, lg_s}) - $signed({1'b0, lg_0});
    assign l_r     = $signed({1'b0, lg_r}) - $signed({1'b0, lg_0});
    assign prod_s  = l_s * alpha_s;
    assign prod_r  = l_r * alpha_s;

    // floor division by 2^20 is the arithmetic bit slice
    always_ff @(posedge clk)
    begin
        if (en[ST_Y])
        begin
            y_s_reg <= prod_s[ALPHA_W+Y_W-1:ALPHA_W];
            y_r_reg <= prod_r[ALPHA_W+Y_W-1:ALPHA_W];
        end
    end

    // ---------------- pressure power terms ----------------
    logic [POW_W-1:0] pow_s;
    logic [POW_W-1:0] pow_r;

    bra_exp2 u_exp_s (.clk(clk), .en(en[ST_EXA+1:ST_EXA]), .y(y_s_reg), .pow(pow_s));
    bra_exp2 u_exp_r (.clk(clk), .en(en[ST_EXA+1:ST_EXA]), .y(y_r_reg), .pow(pow_r));

    // power difference, kept as magnitude and sign
    logic signed [POW_W:0] d;
    logic [POW_W-1:0]      dm_reg;
    logic                  dneg_reg;

    assign d = $signed({1'b0, pow_r}) - $signed({1'b0, pow_s});

    always_ff @(posedge clk)
    begin
        if (en[ST_D])
        begin
            dneg_reg <= d[POW_W];
            dm_reg   <= d[POW_W] ? POW_W'(-d) : POW_W'(d);
        end
    end

    // hold the difference until the divider catches up
    logic [POW_W-1:0] dly_dm_reg   [DLY_N];
    logic             dly_neg_reg  [DLY_N];

    for (genvar k = 0; k < DLY_N; k++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en[ST_D+1+k])
            begin
                if (k == 0)
                begin
                    dly_dm_reg[k]  <= dm_reg;
                    dly_neg_reg[k] <= dneg_reg;
                end
                else
                begin
                    dly_dm_reg[k]  <= dly_dm_reg[k-1];
                    dly_neg_reg[k] <= dly_neg_reg[k-1];
                end
            end
        end
    end

    // ---------------- (T/L) * |D| as four partial products ----------------
    logic [Q_LO_W+DM_LO_W-1:0] p00_reg;
    logic [Q_LO_W+DM_HI_W-1:0] p01_reg;
    logic [Q_HI_W+DM_LO_W-1:0] p10_reg;
    logic [Q_HI_W+DM_HI_W-1:0] p11_reg;
    logic [Q_LO_W-1:0]         q_lo;
    logic [Q_HI_W-1:0]         q_hi;
    logic [DM_LO_W-1:0]        dm_lo;
    logic [DM_HI_W-1:0]        dm_hi;
    logic                      neg_pp_reg;

    assign q_lo  = q16[Q_LO_W-1:0];
    assign q_hi  = q16[NUM_W-1:Q_LO_W];
    assign dm_lo = dly_dm_reg[DLY_N-1][DM_LO_W-1:0];
    assign dm_hi = dly_dm_reg[DLY_N-1][POW_W-1:DM_LO_W];

    always_ff @(posedge clk)
    begin
        if (en[ST_PP])
        begin
            p00_reg    <= (Q_LO_W+DM_LO_W)'(q_lo) * (Q_LO_W+DM_LO_W)'(dm_lo);
            p01_reg    <= (Q_LO_W+DM_HI_W)'(q_lo) * (Q_LO_W+DM_HI_W)'(dm_hi);
            p10_reg    <= (Q_HI_W+DM_LO_W)'(q_hi) * (Q_HI_W+DM_LO_W)'(dm_lo);
            p11_reg    <= (Q_HI_W+DM_HI_W)'(q_hi) * (Q_HI_W+DM_HI_W)'(dm_hi);
            neg_pp_reg <= dly_neg_reg[DLY_N-1];
        end
    end

    logic [PROD_W-1:0] a_reg;
    logic [PROD_W-1:0] b_reg;
    logic              neg_sum_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            a_reg       <= PROD_W'(p00_reg) + (PROD_W'(p01_reg) << DM_LO_W);
            b_reg       <= PROD_W'(p10_reg) + (PROD_W'(p11_reg) << DM_LO_W);
            neg_sum_reg <= neg_pp_reg;
        end
    end

    logic [PROD_W-1:0] full_reg;
    logic              neg_full_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_FULL])
        begin
            full_reg     <= a_reg + (b_reg << Q_LO_W);
            neg_full_reg <= neg_sum_reg;
        end
    end

    // drop the fraction and cap the magnitude
    logic [PROD_W-1:0] dq_full;
    logic [DQ_W-1:0]   dq_reg;
    logic              neg_dq_reg;

    assign dq_full = full_reg >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en[ST_DQ])
        begin
            dq_reg     <= (dq_full > PROD_W'(DQ_CAP)) ? DQ_CAP : dq_full[DQ_W-1:0];
            neg_dq_reg <= neg_full_reg;
        end
    end

    // ---------------- reference altitude plus difference, Q16 cm ----------------
    logic signed [S_W-1:0] href_q16;
    logic signed [S_W-1:0] dq_s;
    logic signed [S_W-1:0] s_reg;

    assign href_q16 = S_W'($signed(ref_altitude_reg)) <<< GAIN_FRAC;
    assign dq_s     = $signed({2'b00, dq_reg});

    always_ff @(posedge clk)
    begin
        if (en[ST_S]) s_reg <= href_q16 + (neg_dq_reg ? -dq_s : dq_s);
    end

    logic [SM_W-1:0] sm_reg;
    logic            sneg_sm_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SM])
        begin
            sneg_sm_reg <= s_reg[S_W-1];
            sm_reg      <= s_reg[S_W-1] ? SM_W'(-s_reg) : SM_W'(s_reg);
        end
    end

    // ---------------- gain, rounding half away from zero ----------------
    logic [SM_LO_W+GAIN_W-1:0] gp0_reg;
    logic [SM_HI_W+GAIN_W-1:0] gp1_reg;
    logic                      sneg_gp_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_GP])
        begin
            gp0_reg     <= (SM_LO_W+GAIN_W)'(sm_reg[SM_LO_W-1:0])
                           * (SM_LO_W+GAIN_W)'(scale_gain_reg);
            gp1_reg     <= (SM_HI_W+GAIN_W)'(sm_reg[SM_W-1:SM_LO_W])
                           * (SM_HI_W+GAIN_W)'(scale_gain_reg);
            sneg_gp_reg <= sneg_sm_reg;
        end
    end

    logic [TOT_W-1:0] tot_reg;
    logic             sneg_tot_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_TOT])
        begin
            tot_reg      <= TOT_W'(gp0_reg) + (TOT_W'(gp1_reg) << SM_LO_W)
                            + (TOT_W'(1) << (RND_SH - 1));
            sneg_tot_reg <= sneg_gp_reg;
        end
    end

    logic [TOT_W-1:0] am_full;
    logic [AM_W-1:0]  am_reg;
    logic             sneg_am_reg;

    assign am_full = tot_reg >> RND_SH;

    always_ff @(posedge clk)
    begin
        if (en[ST_AM])
        begin
            am_reg      <= (am_full > TOT_W'(AM_CAP)) ? AM_CAP : am_full[AM_W-1:0];
            sneg_am_reg <= sneg_tot_reg;
        end
    end

    // ---------------- sign, clip and output register ----------------
    logic signed [V_W-1:0]   val;
    logic signed [ALT_W-1:0] alt_next;
    logic                    sat_next;
    logic signed [ALT_W-1:0] alt_reg;
    logic                    sat_reg;

    always_comb
    begin
        val = sneg_am_reg ? -$signed({1'b0, am_reg}) : $signed({1'b0, am_reg});
        if (val > V_W'(OUT_HIGH))
        begin
            alt_next = ALT_W'(OUT_HIGH);
            sat_next = 1'b1;
        end
        else if (val < V_W'(OUT_LOW))
        begin
            alt_next = ALT_W'(OUT_LOW);
            sat_next = 1'b1;
        end
        else
        begin
            alt_next = val[ALT_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTAGE])
        begin
            alt_reg <= alt_next;
            sat_reg <= sat_next;
        end
    end

    assign result.valid       = v_reg[NSTAGE];
    assign result.altitude_cm = alt_reg;
    assign result.saturated   = sat_reg;

`ifndef SYNTHESIS
    // a waiting result keeps its value
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.altitude_cm)
                                          && $stable(result.saturated))
        else $error("result changed while stalled");

    // a clipped result sits on one of the bounds
    a_sat_bound : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |->
            result.altitude_cm == ALT_W'(OUT_HIGH) || result.altitude_cm == ALT_W'(OUT_LOW))
        else $error("saturated result off the bounds");

    // every delivered altitude lies in range
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.altitude_cm <= ALT_W'(OUT_HIGH)
                         && result.altitude_cm >= ALT_W'(OUT_LOW))
        else $error("altitude out of range");
`endif

endmodule
